[rtl/core/ibm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_pkg
// types, codes and constants shared by the i2c byte master files
// ----------------------------------------------------------------------------
package ibm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam int WAIT_W          = 17;

  localparam logic [CFG_W-1:0]  UNIT_TICKS_RST  = 16'd100;
  localparam logic [CFG_W-1:0]  ACK_TIMEOUT_RST = 16'd250;
  localparam logic [WAIT_W-1:0] WAIT_MAX        = 17'h1FFFF;
  localparam logic [3:0]        BITS_PER_BYTE   = 4'd8;

  localparam logic [2:0] UNITS_EDGE = 3'd4;
  localparam logic [2:0] UNITS_BIT  = 3'd2;
  localparam logic [2:0] UNITS_ONE  = 3'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } ibm_op_t;

  typedef enum logic [0:0] {
    REG_UNIT_TICKS  = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } ibm_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_A    = 4'd1,
    PH_START_B    = 4'd2,
    PH_STOP_A     = 4'd3,
    PH_STOP_B     = 4'd4,
    PH_WR_LOW     = 4'd5,
    PH_WR_HIGH    = 4'd6,
    PH_WR_TAIL    = 4'd7,
    PH_ACK_REL    = 4'd8,
    PH_ACK_HIGH   = 4'd9,
    PH_ACK_POLL   = 4'd10,
    PH_RD_LOW     = 4'd11,
    PH_RD_HIGH    = 4'd12,
    PH_RDACK_LOW  = 4'd13,
    PH_RDACK_HIGH = 4'd14
  } ibm_phase_t;

  typedef struct packed {
    logic       cmd_valid;
    ibm_op_t    operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } ibm_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } ibm_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] unit_ticks;
    logic [CFG_W-1:0] ack_timeout;
  } ibm_cfg_t;

endpackage

[rtl/core/i2c_byte_master_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_byte_master_top
// i2c master byte engine: start, stop, byte write with ack wait, byte read
//
//   channel  handshake               payload
//   in       in_valid / in_ready     cmd_valid operation tx_byte send_ack sda_in
//   out      out_valid / out_ready   scl sda_out sda_drive busy_res done_res
//                                    rx_byte ack_error
//   cfg      apb write, pready high  unit_ticks (0x0), ack_timeout (0x4)
//
// one tick item per cycle while the result is taken; each result passes the input
// register, then the phase sequencer into the result register
// reset clears the sequencer to idle with scl high and sda released,
// unit_ticks to 100 and ack_timeout to 250
// out_ready low holds the result; the input register still takes one item
// ----------------------------------------------------------------------------
module i2c_byte_master_top
  import ibm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd_valid,
  input  logic [1:0]         operation,
  input  logic [7:0]         tx_byte,
  input  logic               send_ack,
  input  logic               sda_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               scl,
  output logic               sda_out,
  output logic               sda_drive,
  output logic               busy_res,
  output logic               done_res,
  output logic [7:0]         rx_byte,
  output logic               ack_error
);

  ibm_cfg_t    cfg;
  ibm_item_t   in_item;
  ibm_item_t   q_item;
  logic        q_valid;
  logic        take;
  ibm_result_t result;

  assign in_item.cmd_valid = cmd_valid;
  assign in_item.operation = ibm_op_t'(operation);
  assign in_item.tx_byte   = tx_byte;
  assign in_item.send_ack  = send_ack;
  assign in_item.sda_in    = sda_in;

  ibm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ibm_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  ibm_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_valid),
    .item       (q_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign scl       = result.scl;
  assign sda_out   = result.sda_out;
  assign sda_drive = result.sda_drive;
  assign busy_res  = result.busy_res;
  assign done_res  = result.done_res;
  assign rx_byte   = result.rx_byte;
  assign ack_error = result.ack_error;

endmodule

[rtl/core/ibm_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_apb_regs
// apb configuration registers: unit ticks and ack timeout
// ----------------------------------------------------------------------------
module ibm_apb_regs
  import ibm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ibm_cfg_t           cfg
);

  ibm_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = ibm_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_ticks  <= UNIT_TICKS_RST;
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_UNIT_TICKS:  cfg.unit_ticks  <= pwdata[CFG_W-1:0];
        REG_ACK_TIMEOUT: cfg.ack_timeout <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_UNIT_TICKS:  prdata = PDATA_W'(cfg.unit_ticks);
      REG_ACK_TIMEOUT: prdata = PDATA_W'(cfg.ack_timeout);
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/core/ibm_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_in_reg
// input register for one tick item, drained by the engine
// ----------------------------------------------------------------------------
module ibm_in_reg
  import ibm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ibm_item_t in_item,
  input  logic      take,
  output logic      q_valid,
  output ibm_item_t q_item
);

  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item <= in_item;
    end
  end

endmodule

[rtl/core/ibm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_engine
// bus phase sequencer: one tick per item, result register on the output
// ----------------------------------------------------------------------------
module ibm_engine
  import ibm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ibm_cfg_t    cfg,
  input  logic        item_valid,
  input  ibm_item_t   item,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output ibm_result_t result
);

  localparam int UW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  ibm_phase_t             phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_next;
  logic [2:0]             unit_cnt, unit_cnt_next;
  logic [2:0]             seg_units, seg_units_next;
  logic [3:0]             bit_count, bit_next;
  logic [7:0]             shift_reg, shift_next;
  logic [WAIT_W-1:0]      wait_count, wait_next;
  logic                   ack_choice, ack_choice_next;
  logic                   pin_scl, scl_next;
  logic                   pin_sda, sda_next;
  logic                   pin_drive, drive_next;
  logic                   error_flag, err_next;
  logic [7:0]             rx_hold, rx_next;

  logic [UW-1:0]          unit_ext;
  logic [UW-1:0]          cmax_ext;
  logic [UW-1:0]          u_wide;
  logic [COUNT_WIDTH-1:0] u_eff;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   unit_hit;
  logic                   seg_end;
  logic [WAIT_W-1:0]      wait_inc;

  logic       done;
  logic       seg_load;
  logic       pin_load;
  ibm_phase_t seg_ph;
  logic [2:0] seg_n;
  logic       set_c;
  logic       set_d;
  logic       set_drv;

  // effective unit length: zero acts as one, clamp to counter range
  assign unit_ext = UW'(cfg.unit_ticks);
  assign cmax_ext = UW'({COUNT_WIDTH{1'b1}});
  always_comb begin
    if (unit_ext == '0) begin
      u_wide = UW'(1);
    end else if (unit_ext > cmax_ext) begin
      u_wide = cmax_ext;
    end else begin
      u_wide = unit_ext;
    end
  end
  assign u_eff    = u_wide[COUNT_WIDTH-1:0];
  assign tick_inc = tick_count + COUNT_WIDTH'(1);
  assign unit_hit = tick_inc >= u_eff;
  assign seg_end  = unit_hit && (3'(unit_cnt + 3'd1) >= seg_units);
  assign wait_inc = (wait_count != WAIT_MAX) ? wait_count + WAIT_W'(1) : wait_count;

  assign take = item_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next      = phase;
    tick_next       = tick_count;
    unit_cnt_next   = unit_cnt;
    seg_units_next  = seg_units;
    bit_next        = bit_count;
    shift_next      = shift_reg;
    wait_next       = wait_count;
    ack_choice_next = ack_choice;
    err_next        = error_flag;
    rx_next         = rx_hold;
    done            = 1'b0;
    seg_load        = 1'b0;
    pin_load        = 1'b0;
    seg_ph          = phase;
    seg_n           = seg_units;
    set_c           = pin_scl;
    set_d           = pin_sda;
    set_drv         = pin_drive;

    unique case (phase)
      PH_IDLE: begin
        if (item.cmd_valid) begin
          bit_next = '0;
          seg_load = 1'b1;
          unique case (item.operation)
            OP_START: begin
              seg_ph = PH_START_A; seg_n = UNITS_EDGE;
              set_c = 1'b1; set_d = 1'b1; set_drv = 1'b1;
            end
            OP_STOP: begin
              seg_ph = PH_STOP_A; seg_n = UNITS_EDGE;
              set_c = 1'b0; set_d = 1'b0; set_drv = 1'b1;
            end
            OP_WRITE: begin
              shift_next = item.tx_byte;
              err_next   = 1'b0;
              seg_ph = PH_WR_LOW; seg_n = UNITS_BIT;
              set_c = 1'b0; set_d = item.tx_byte[7]; set_drv = 1'b1;
            end
            OP_READ: begin
              ack_choice_next = item.send_ack;
              shift_next      = '0;
              seg_ph = PH_RD_LOW; seg_n = UNITS_BIT;
              set_c = 1'b0; set_d = 1'b1; set_drv = 1'b0;
            end
            default: ;
          endcase
        end
      end
      PH_ACK_POLL: begin
        if (!item.sda_in) begin
          phase_next = PH_IDLE;
          pin_load   = 1'b1;
          set_c = 1'b0; set_d = 1'b1; set_drv = 1'b0;
          done       = 1'b1;
        end else begin
          wait_next = wait_inc;
          if (wait_inc > WAIT_W'(cfg.ack_timeout)) begin
            err_next = 1'b1;
            seg_load = 1'b1;
            seg_ph = PH_STOP_A; seg_n = UNITS_EDGE;
            set_c = 1'b0; set_d = 1'b0; set_drv = 1'b1;
          end
        end
      end
      default: begin
        tick_next     = unit_hit ? '0 : tick_inc;
        unit_cnt_next = unit_hit ? 3'(unit_cnt + 3'd1) : unit_cnt;
        if (seg_end) begin
          unique case (phase)
            PH_START_A: begin
              seg_load = 1'b1;
              seg_ph = PH_START_B; seg_n = UNITS_EDGE;
              set_c = 1'b1; set_d = 1'b0; set_drv = 1'b1;
            end
            PH_START_B: begin
              phase_next = PH_IDLE;
              pin_load   = 1'b1;
              set_c = 1'b0; set_d = 1'b0; set_drv = 1'b1;
              done       = 1'b1;
            end
            PH_STOP_A: begin
              seg_load = 1'b1;
              seg_ph = PH_STOP_B; seg_n = UNITS_EDGE;
              set_c = 1'b1; set_d = 1'b1; set_drv = 1'b1;
            end
            PH_STOP_B: begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
            PH_WR_LOW: begin
              seg_load = 1'b1;
              seg_ph = PH_WR_HIGH; seg_n = UNITS_BIT;
              set_c = 1'b1; set_d = pin_sda; set_drv = 1'b1;
            end
            PH_WR_HIGH: begin
              seg_load = 1'b1;
              seg_ph = PH_WR_TAIL; seg_n = UNITS_BIT;
              set_c = 1'b0; set_d = pin_sda; set_drv = 1'b1;
            end
            PH_WR_TAIL: begin
              bit_next   = 4'(bit_count + 4'd1);
              shift_next = {shift_reg[6:0], 1'b0};
              seg_load   = 1'b1;
              if (bit_next < BITS_PER_BYTE) begin
                seg_ph = PH_WR_LOW; seg_n = UNITS_BIT;
                set_c = 1'b0; set_d = shift_reg[6]; set_drv = 1'b1;
              end else begin
                wait_next = '0;
                seg_ph = PH_ACK_REL; seg_n = UNITS_ONE;
                set_c = 1'b0; set_d = 1'b1; set_drv = 1'b0;
              end
            end
            PH_ACK_REL: begin
              seg_load = 1'b1;
              seg_ph = PH_ACK_HIGH; seg_n = UNITS_ONE;
              set_c = 1'b1; set_d = 1'b1; set_drv = 1'b0;
            end
            PH_ACK_HIGH: begin
              phase_next = PH_ACK_POLL;
            end
            PH_RD_LOW: begin
              shift_next = {shift_reg[6:0], item.sda_in};
              seg_load   = 1'b1;
              seg_ph = PH_RD_HIGH; seg_n = UNITS_ONE;
              set_c = 1'b1; set_d = 1'b1; set_drv = 1'b0;
            end
            PH_RD_HIGH: begin
              bit_next = 4'(bit_count + 4'd1);
              seg_load = 1'b1;
              seg_n    = UNITS_BIT;
              set_c    = 1'b0;
              if (bit_next < BITS_PER_BYTE) begin
                seg_ph = PH_RD_LOW; set_d = 1'b1; set_drv = 1'b0;
              end else begin
                seg_ph = PH_RDACK_LOW; set_d = !ack_choice; set_drv = 1'b1;
              end
            end
            PH_RDACK_LOW: begin
              seg_load = 1'b1;
              seg_ph = PH_RDACK_HIGH; seg_n = UNITS_BIT;
              set_c = 1'b1; set_d = pin_sda; set_drv = 1'b1;
            end
            PH_RDACK_HIGH: begin
              phase_next = PH_IDLE;
              pin_load   = 1'b1;
              set_c = 1'b0; set_d = pin_sda; set_drv = 1'b1;
              rx_next    = shift_reg;
              done       = 1'b1;
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
    endcase

    if (seg_load) begin
      phase_next     = seg_ph;
      seg_units_next = seg_n;
      unit_cnt_next  = '0;
      tick_next      = '0;
    end
    scl_next   = (seg_load || pin_load) ? set_c : pin_scl;
    drive_next = (seg_load || pin_load) ? set_drv : pin_drive;
    sda_next   = (seg_load || pin_load) ? (set_drv ? set_d : 1'b1) : pin_sda;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      unit_cnt   <= '0;
      seg_units  <= '0;
      bit_count  <= '0;
      shift_reg  <= '0;
      wait_count <= '0;
      ack_choice <= 1'b0;
      pin_scl    <= 1'b1;
      pin_sda    <= 1'b1;
      pin_drive  <= 1'b0;
      error_flag <= 1'b0;
      rx_hold    <= '0;
    end else if (take) begin
      phase      <= phase_next;
      tick_count <= tick_next;
      unit_cnt   <= unit_cnt_next;
      seg_units  <= seg_units_next;
      bit_count  <= bit_next;
      shift_reg  <= shift_next;
      wait_count <= wait_next;
      ack_choice <= ack_choice_next;
      pin_scl    <= scl_next;
      pin_sda    <= sda_next;
      pin_drive  <= drive_next;
      error_flag <= err_next;
      rx_hold    <= rx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.scl       <= scl_next;
      result.sda_out   <= sda_next;
      result.sda_drive <= drive_next;
      result.busy_res  <= (phase_next != PH_IDLE);
      result.done_res  <= done;
      result.rx_byte   <= rx_next;
      result.ack_error <= err_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result.done_res && result.busy_res))
    else $error("done and busy in one result");

  a_released_high: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.sda_drive) |-> result.sda_out)
    else $error("released sda not reading high");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase) && $stable(tick_count))
    else $error("engine state moved without a transfer");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit count out of range");

endmodule

[verif/tb_i2c_byte_master_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_byte_master_top
// self-checking bench for the i2c byte master tick engine
//
// every tick item is run through a cycle-level model of the bus sequencer and
// the predicted pin state is queued; each result transfer is compared field by
// field with the oldest prediction. directed commands cover the reset pin
// levels, a zero unit, a wide timeout, ack at the timeout boundary, ack loss
// with the automatic stop and both read acknowledge choices. random i2c
// transactions follow under several timing settings and idle/stall mixes,
// including a long receiver hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module tb_i2c_byte_master_top;
  import ibm_pkg::*;

  localparam int          NEVER_ACK   = 32'h7FFF_FFFF;
  localparam int          HOLD_CYCLES = 300;
  localparam int          QUIET_LIMIT = 4000;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_WIDTH_DEF) - 1;

  class pin_board;
    int unsigned                unit_ticks;
    int unsigned                ack_timeout;
    ibm_phase_t                 phase;
    logic [COUNT_WIDTH_DEF-1:0] tick_count;
    logic [3:0]                 bit_count;
    logic [7:0]                 shift_reg;
    logic [7:0]                 rx_hold;
    logic [WAIT_W-1:0]          wait_count;
    logic                       ack_choice;
    logic                       pin_scl;
    logic                       pin_sda;
    logic                       pin_drive;
    logic                       error_flag;
    int unsigned                seg_units;
    int unsigned                units_done;
    int unsigned                result_no;
    ibm_result_t                pins_due[$];

    function new();
      unit_ticks  = 32'(UNIT_TICKS_RST);
      ack_timeout = 32'(ACK_TIMEOUT_RST);
      phase       = PH_IDLE;
      tick_count  = '0;
      bit_count   = '0;
      shift_reg   = '0;
      rx_hold     = '0;
      wait_count  = '0;
      ack_choice  = 1'b0;
      pin_scl     = 1'b1;
      pin_sda     = 1'b1;
      pin_drive   = 1'b0;
      error_flag  = 1'b0;
      seg_units   = 0;
      units_done  = 0;
      result_no   = 0;
    endfunction

    function void set_reg(ibm_reg_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_UNIT_TICKS) unit_ticks = 32'(value);
      else ack_timeout = 32'(value);
    endfunction

    function int pending();
      return pins_due.size();
    endfunction

    function void drive_pins(logic c, logic d, logic drv);
      pin_scl   = c;
      pin_drive = drv;
      pin_sda   = drv ? d : 1'b1;
    endfunction

    function void enter(ibm_phase_t ph, logic [2:0] units, logic c, logic d, logic drv);
      phase      = ph;
      seg_units  = 32'(units);
      units_done = 0;
      tick_count = '0;
      drive_pins(c, d, drv);
    endfunction

    function bit unit_over();
      int unsigned u;
      u = (unit_ticks == 0) ? 1 : unit_ticks;
      if (u > COUNT_MAX) u = COUNT_MAX;
      tick_count = tick_count + 1'b1;
      if (32'(tick_count) >= u) begin
        tick_count = '0;
        units_done++;
        return units_done >= seg_units;
      end
      return 1'b0;
    endfunction

    function void take_tick(ibm_item_t it);
      ibm_result_t r;
      logic        done;
      done = 1'b0;
      if (phase == PH_IDLE) begin
        if (it.cmd_valid) begin
          bit_count = '0;
          case (it.operation)
            OP_START: enter(PH_START_A, UNITS_EDGE, 1'b1, 1'b1, 1'b1);
            OP_STOP:  enter(PH_STOP_A, UNITS_EDGE, 1'b0, 1'b0, 1'b1);
            OP_WRITE: begin
              shift_reg  = it.tx_byte;
              error_flag = 1'b0;
              enter(PH_WR_LOW, UNITS_BIT, 1'b0, shift_reg[7], 1'b1);
            end
            default: begin
              ack_choice = it.send_ack;
              shift_reg  = '0;
              enter(PH_RD_LOW, UNITS_BIT, 1'b0, 1'b1, 1'b0);
            end
          endcase
        end
      end else if (phase == PH_ACK_POLL) begin
        if (!it.sda_in) begin
          phase = PH_IDLE;
          drive_pins(1'b0, 1'b1, 1'b0);
          done = 1'b1;
        end else begin
          if (wait_count < WAIT_MAX) wait_count++;
          if (32'(wait_count) > ack_timeout) begin
            error_flag = 1'b1;
            enter(PH_STOP_A, UNITS_EDGE, 1'b0, 1'b0, 1'b1);
          end
        end
      end else if (unit_over()) begin
        case (phase)
          PH_START_A: enter(PH_START_B, UNITS_EDGE, 1'b1, 1'b0, 1'b1);
          PH_START_B: begin
            phase = PH_IDLE;
            drive_pins(1'b0, 1'b0, 1'b1);
            done = 1'b1;
          end
          PH_STOP_A: enter(PH_STOP_B, UNITS_EDGE, 1'b1, 1'b1, 1'b1);
          PH_STOP_B: begin
            phase = PH_IDLE;
            done  = 1'b1;
          end
          PH_WR_LOW:  enter(PH_WR_HIGH, UNITS_BIT, 1'b1, pin_sda, 1'b1);
          PH_WR_HIGH: enter(PH_WR_TAIL, UNITS_BIT, 1'b0, pin_sda, 1'b1);
          PH_WR_TAIL: begin
            bit_count = bit_count + 1'b1;
            shift_reg = {shift_reg[6:0], 1'b0};
            if (bit_count < BITS_PER_BYTE) begin
              enter(PH_WR_LOW, UNITS_BIT, 1'b0, shift_reg[7], 1'b1);
            end else begin
              wait_count = '0;
              enter(PH_ACK_REL, UNITS_ONE, 1'b0, 1'b1, 1'b0);
            end
          end
          PH_ACK_REL:  enter(PH_ACK_HIGH, UNITS_ONE, 1'b1, 1'b1, 1'b0);
          PH_ACK_HIGH: phase = PH_ACK_POLL;
          PH_RD_LOW: begin
            shift_reg = {shift_reg[6:0], it.sda_in};
            enter(PH_RD_HIGH, UNITS_ONE, 1'b1, 1'b1, 1'b0);
          end
          PH_RD_HIGH: begin
            bit_count = bit_count + 1'b1;
            if (bit_count < BITS_PER_BYTE)
              enter(PH_RD_LOW, UNITS_BIT, 1'b0, 1'b1, 1'b0);
            else
              enter(PH_RDACK_LOW, UNITS_BIT, 1'b0, ack_choice == 1'b0, 1'b1);
          end
          PH_RDACK_LOW: enter(PH_RDACK_HIGH, UNITS_BIT, 1'b1, pin_sda, 1'b1);
          PH_RDACK_HIGH: begin
            phase = PH_IDLE;
            drive_pins(1'b0, pin_sda, 1'b1);
            rx_hold = shift_reg;
            done    = 1'b1;
          end
          default: phase = PH_IDLE;
        endcase
      end
      r.scl       = pin_scl;
      r.sda_out   = pin_sda;
      r.sda_drive = pin_drive;
      r.busy_res  = (phase != PH_IDLE);
      r.done_res  = done;
      r.rx_byte   = rx_hold;
      r.ack_error = error_flag;
      pins_due.push_back(r);
    endfunction

    function string check_pins(ibm_result_t got);
      ibm_result_t want;
      string       bad;
      result_no++;
      if (pins_due.size() == 0)
        return $sformatf("result %0d with nothing expected: %h", result_no, got);
      want = pins_due.pop_front();
      bad  = "";
      if (got.scl !== want.scl) bad = {bad, " scl"};
      if (got.sda_out !== want.sda_out) bad = {bad, " sda_out"};
      if (got.sda_drive !== want.sda_drive) bad = {bad, " sda_drive"};
      if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
      if (got.done_res !== want.done_res) bad = {bad, " done_res"};
      if (got.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
      if (got.ack_error !== want.ack_error) bad = {bad, " ack_error"};
      if (bad == "") return "";
      return $sformatf("result %0d differs in%s: got %h want %h", result_no, bad, got, want);
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               cmd_valid = 1'b0;
  logic [1:0]         operation = '0;
  logic [7:0]         tx_byte   = '0;
  logic               send_ack  = 1'b0;
  logic               sda_in    = 1'b1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               scl;
  logic               sda_out;
  logic               sda_drive;
  logic               busy_res;
  logic               done_res;
  logic [7:0]         rx_byte;
  logic               ack_error;

  pin_board board;
  int       errors     = 0;
  int       ticks_sent = 0;
  int       idle_pct   = 0;
  int       stall_pct  = 0;
  int       hold_req   = 0;
  int       hold_seen  = 0;
  int       hold_left  = 0;
  int       quiet      = 0;

  i2c_byte_master_top uut (.*);

  always #5 clk = ~clk;

  task report_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      msg = board.check_pins({scl, sda_out, sda_drive, busy_res, done_res, rx_byte, ack_error});
      if (msg != "") report_mismatch(msg);
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task reg_write(ibm_reg_t idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
  endtask

  task new_setting(logic [CFG_W-1:0] unit, logic [CFG_W-1:0] limit, int idle, int stall);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    reg_write(REG_UNIT_TICKS, unit);
    reg_write(REG_ACK_TIMEOUT, limit);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task send_tick(ibm_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    cmd_valid <= it.cmd_valid;
    operation <= it.operation;
    tx_byte   <= it.tx_byte;
    send_ack  <= it.send_ack;
    sda_in    <= it.sda_in;
    do @(posedge clk); while (!in_ready);
    board.take_tick(it);
    ticks_sent++;
  endtask

  // command tick, then ticks until the sequencer is idle again
  task run_command(ibm_op_t op, logic [7:0] data, logic ack_bit, int ack_wait,
                   logic [7:0] rd_bits);
    ibm_item_t it;
    int        polls;
    polls        = 0;
    it.cmd_valid = 1'b1;
    it.operation = op;
    it.tx_byte   = data;
    it.send_ack  = ack_bit;
    it.sda_in    = 1'($urandom_range(1));
    send_tick(it);
    while (board.phase != PH_IDLE) begin
      it.cmd_valid = ($urandom_range(3) == 0);
      it.operation = ibm_op_t'(2'($urandom_range(3)));
      it.tx_byte   = 8'($urandom);
      it.send_ack  = 1'($urandom_range(1));
      case (board.phase)
        PH_ACK_POLL: begin
          it.sda_in = (polls >= ack_wait) ? 1'b0 : 1'b1;
          polls++;
        end
        PH_RD_LOW: it.sda_in = rd_bits[3'(4'd7 - board.bit_count)];
        default:   it.sda_in = 1'($urandom_range(1));
      endcase
      send_tick(it);
    end
  endtask

  task run_random(ibm_op_t op);
    int ack_wait;
    ack_wait = ($urandom_range(4) == 0) ? NEVER_ACK : $urandom_range(board.ack_timeout + 2);
    run_command(op, 8'($urandom), 1'($urandom_range(1)), ack_wait, 8'($urandom));
  endtask

  task noise_ticks(int n);
    ibm_item_t it;
    repeat (n) begin
      it.cmd_valid = 1'b0;
      it.operation = ibm_op_t'(2'($urandom_range(3)));
      it.tx_byte   = 8'($urandom);
      it.send_ack  = 1'($urandom_range(1));
      it.sda_in    = 1'($urandom_range(1));
      send_tick(it);
    end
  endtask

  task random_traffic(int count);
    int stop_at;
    int pick;
    int n;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        run_random(OP_START);
        n = $urandom_range(1, 3);
        repeat (n) run_random($urandom_range(1) ? OP_WRITE : OP_READ);
        run_random(OP_STOP);
      end else if (pick < 9) begin
        run_random(ibm_op_t'(2'($urandom_range(3))));
      end else begin
        noise_ticks($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // pin levels out of reset
    noise_ticks(4);

    new_setting(16'd1, 16'd4, 0, 0);
    run_command(OP_START, 8'h00, 1'b0, 0, 8'h00);
    run_command(OP_WRITE, 8'h00, 1'b0, NEVER_ACK, 8'h00);
    run_command(OP_WRITE, 8'hA5, 1'b0, 4, 8'h00);
    run_command(OP_READ, 8'h00, 1'b1, 0, 8'h00);
    run_command(OP_READ, 8'hFF, 1'b0, 0, 8'hFF);
    run_command(OP_STOP, 8'h00, 1'b0, 0, 8'h00);

    // zero unit behaves as one tick
    new_setting(16'd0, 16'd1, 0, 0);
    run_command(OP_READ, 8'h00, 1'b1, 0, 8'hC3);

    new_setting(16'd1, 16'hFFFF, 0, 0);
    run_command(OP_WRITE, 8'h81, 1'b0, 3, 8'h00);

    new_setting(16'd1, 16'($urandom_range(1, 12)), 0, 0);
    hold_req++;
    random_traffic(20);
    new_setting(16'd1, 16'($urandom_range(1, 12)), 80, 0);
    random_traffic(20);
    new_setting(16'd1, 16'($urandom_range(1, 12)), 0, 80);
    random_traffic(20);
    new_setting(16'd1, 16'($urandom_range(1, 12)), 14, 14);
    random_traffic(20);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
